@@ hdl/icfc_pkg.sv @@
// shared types and constants of the ir command frame checker
// used by every module of the block, depends on nothing
`default_nettype none

package icfc_pkg;

    localparam int FRAME_BYTES  = 8;
    localparam int MAX_COMMANDS = 16;
    localparam int LISTENERS    = 16;
    localparam int IDX_W        = $clog2(FRAME_BYTES);
    localparam int CNT_W        = $clog2(FRAME_BYTES + 2);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FIRST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SECOND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_MASK      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_MASK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_MASK = 3'd6;

    typedef logic [FRAME_BYTES-1:0][7:0] t_bytes;

    typedef struct packed {
        logic        len_ok;
        t_bytes      bytes;
        logic [31:0] stamp;
    } t_frame;

    typedef struct packed {
        logic [7:0]           head_first;
        logic [7:0]           head_second;
        logic [7:0]           tail_first;
        logic [7:0]           tail_second;
        logic [7:0]           sum_mask;
        logic [7:0]           toggle_mask;
        logic [LISTENERS-1:0] listener_mask;
    } t_cfg;

endpackage

`default_nettype wire

@@ hdl/icfc_front.sv @@
// front end: collects received words into the frame buffer and counts them
// pushes a frame record into the queue on every chunk end, uses icfc_pkg
`default_nettype none

module icfc_front
    import icfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_chunk_end,
    input  wire logic [31:0] i_now_stamp,
    output logic             o_push,
    output t_frame           o_frame
);

    logic [CNT_W-1:0] r_count, n_count;
    t_bytes           r_buf, n_buf;
    logic             store;

    assign store = r_count < CNT_W'(FRAME_BYTES);

    always_comb begin
        n_buf = r_buf;
        if (store) begin
            n_buf[r_count[IDX_W-1:0]] = i_rx_byte;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_accept) begin
            if (i_chunk_end) begin
                n_count = '0;
            end else if (store) begin
                n_count = r_count + CNT_W'(1);
            end else if (r_count == CNT_W'(FRAME_BYTES)) begin
                n_count = CNT_W'(FRAME_BYTES + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_buf <= n_buf;
        end
    end

    assign o_push         = i_accept & i_chunk_end;
    assign o_frame.len_ok = r_count == CNT_W'(FRAME_BYTES - 1);
    assign o_frame.bytes  = n_buf;
    assign o_frame.stamp  = i_now_stamp;

endmodule

`default_nettype wire

@@ hdl/icfc_queue.sv @@
// short queue of frame records between front end and checker
// register storage, push and pop in the same cycle, uses icfc_pkg
`default_nettype none

module icfc_queue
    import icfc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_frame i_data,
    input  wire logic   i_pop,
    output logic        o_valid,
    output logic        o_full,
    output t_frame      o_data
);

    t_frame             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               do_push, do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/icfc_back.sv @@
// checker: judges one frame record a cycle unless stalled, tracks the
// last command and the sticky pending flag, holds results, uses icfc_pkg
`default_nettype none

module icfc_back
    import icfc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_frame_valid,
    input  wire t_frame i_frame,
    output logic        o_pop,
    input  wire logic   i_out_stall,
    output logic        o_out_valid,
    output logic        o_frame_good,
    output logic        o_fresh_command,
    output logic [7:0]  o_command_code,
    output logic        o_notify_listener,
    output logic [31:0] o_stamp_out,
    output logic        o_any_pending
);

    logic        r_seen, r_prev_toggle, r_pending, r_out_valid;
    logic [7:0]  r_prev_cmd;
    logic [9:0]  sum;
    logic [15:0] prod;
    logic [7:0]  chk, cmd, k;
    logic        good, toggle, fresh, in_range, notify;

    assign o_pop = i_frame_valid & (~r_out_valid | ~i_out_stall);

    always_comb begin
        sum  = 10'(i_frame.bytes[2]) + 10'(i_frame.bytes[3]) + 10'(i_frame.bytes[4]);
        prod = sum[7:0] * sum[7:0];
        chk  = ~prod[7:0] & i_cfg.sum_mask;
        good = i_frame.len_ok
            && i_frame.bytes[0] == i_cfg.head_first
            && i_frame.bytes[1] == i_cfg.head_second
            && chk == (i_frame.bytes[5] & i_cfg.sum_mask)
            && i_frame.bytes[6] == i_cfg.tail_first
            && i_frame.bytes[7] == i_cfg.tail_second;
        cmd      = i_frame.bytes[4];
        toggle   = |(i_frame.bytes[5] & i_cfg.toggle_mask);
        fresh    = good && (!r_seen || toggle != r_prev_toggle || cmd != r_prev_cmd);
        in_range = cmd != 8'd0 && cmd <= 8'(MAX_COMMANDS);
        k        = cmd - 8'd1;
        notify   = fresh && in_range && cmd <= 8'(LISTENERS)
                   && i_cfg.listener_mask[k[$clog2(LISTENERS)-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= 1'b0;
            r_prev_toggle <= 1'b0;
            r_prev_cmd    <= '0;
            r_pending     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                if (fresh) begin
                    r_seen        <= 1'b1;
                    r_prev_toggle <= toggle;
                    r_prev_cmd    <= cmd;
                end
                if (fresh && in_range) begin
                    r_pending <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_frame_good      <= good;
            o_fresh_command   <= fresh;
            o_command_code    <= good ? cmd : 8'd0;
            o_notify_listener <= notify;
            o_stamp_out       <= notify ? i_frame.stamp : 32'd0;
            o_any_pending     <= r_pending | (fresh & in_range);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ hdl/ir_command_frame_checker.sv @@
// top level of the ir command frame checker: register file, front end,
// queue and checker, uses icfc_pkg, icfc_front, icfc_queue, icfc_back
// a chunk-end word's result is held first in a queue entry, then in the checker's output register
// throughput: one word per cycle, chunk ends included, set by the 2-entry queue
// input stalls only while the queue is full; reset clears all control state
// and loads the register defaults, no clearing pass
`default_nettype none

module ir_command_frame_checker
    import icfc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic                  i_chunk_end,
    input  wire logic [31:0]           i_now_stamp,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_frame_good,
    output logic                       o_fresh_command,
    output logic [7:0]                 o_command_code,
    output logic                       o_notify_listener,
    output logic [31:0]                o_stamp_out,
    output logic                       o_any_pending
);

    t_cfg   r_cfg;
    t_frame push_frame, head_frame;
    logic   in_accept, push, q_valid, q_full, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_first    <= 8'h00;
            r_cfg.head_second   <= 8'h00;
            r_cfg.tail_first    <= 8'h00;
            r_cfg.tail_second   <= 8'h00;
            r_cfg.sum_mask      <= 8'hFF;
            r_cfg.toggle_mask   <= 8'h00;
            r_cfg.listener_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEAD_FIRST:    r_cfg.head_first    <= i_cfg_data[7:0];
                CFG_HEAD_SECOND:   r_cfg.head_second   <= i_cfg_data[7:0];
                CFG_TAIL_FIRST:    r_cfg.tail_first    <= i_cfg_data[7:0];
                CFG_TAIL_SECOND:   r_cfg.tail_second   <= i_cfg_data[7:0];
                CFG_SUM_MASK:      r_cfg.sum_mask      <= i_cfg_data[7:0];
                CFG_TOGGLE_MASK:   r_cfg.toggle_mask   <= i_cfg_data[7:0];
                CFG_LISTENER_MASK: r_cfg.listener_mask <= i_cfg_data[LISTENERS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid & ~q_full;

    icfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .i_chunk_end (i_chunk_end),
        .i_now_stamp (i_now_stamp),
        .o_push      (push),
        .o_frame     (push_frame)
    );

    icfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_frame),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (head_frame)
    );

    icfc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_frame_valid     (q_valid),
        .i_frame           (head_frame),
        .o_pop             (pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_frame_good      (o_frame_good),
        .o_fresh_command   (o_fresh_command),
        .o_command_code    (o_command_code),
        .o_notify_listener (o_notify_listener),
        .o_stamp_out       (o_stamp_out),
        .o_any_pending     (o_any_pending)
    );

    a_pending_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_any_pending) |=> (!o_out_valid || o_any_pending))
        else $error("pending flag dropped");

    a_notify_needs_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_notify_listener) |-> (o_fresh_command && o_frame_good))
        else $error("notification without a fresh good frame");

    a_bad_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_good) |->
        (!o_fresh_command && o_command_code == 8'd0 && o_stamp_out == 32'd0))
        else $error("bad frame carries payload");

    a_stamp_only_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_notify_listener) |-> (o_stamp_out == 32'd0))
        else $error("stamp without notification");

endmodule

`default_nettype wire
